@@ hdl/partial_stereo_pan_smoother_defines.svh @@
// Assertion macros shared by the RTL
`ifndef PARTIAL_STEREO_PAN_SMOOTHER_DEFINES_SVH
`define PARTIAL_STEREO_PAN_SMOOTHER_DEFINES_SVH

// a implies b at the same edge
`define PSPS_ASSERT_IMP(label, c, a, b) \
  label: assert property (@(posedge c) a |-> b) else $error("%m: label");

// a implies b at the following edge
`define PSPS_ASSERT_NEXT(label, c, r, a, b) \
  label: assert property (@(posedge c) disable iff (r) a |=> b) else $error("%m: label");

`endif

@@ hdl/psps_pkg.sv @@
`default_nettype none
package psps_pkg;
  localparam int AMP_W   = 16;
  localparam int LOW_W   = 15;
  localparam int RATIO_W = 17;
  localparam int ROOT_W  = 21;

  localparam logic [1:0] MODE_MONO = 2'd0;
  localparam logic [1:0] MODE_SOFT = 2'd1;
  localparam logic [1:0] MODE_HARD = 2'd2;

  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_SWAP  = 2'd1;
  localparam logic [1:0] REG_LOW   = 2'd2;
  localparam logic [1:0] REG_RATIO = 2'd3;

  typedef struct packed {
    logic [5:0]        partial_index;
    logic signed [15:0] raw_amplitude;
    logic              goes_left;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] left_amplitude;
    logic signed [15:0] right_amplitude;
  } out_word_t;

  typedef struct packed {
    logic [1:0]        stereo_mode;
    logic              swap_sides;
    logic [LOW_W-1:0]  lowest_partial;
    logic [RATIO_W-1:0] smoothing_ratio;
  } cfg_t;

  function automatic logic signed [15:0] sat16(input logic signed [35:0] v);
    if (v > 36'sd32767) return 16'sh7fff;
    if (v < -36'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction
endpackage
`default_nettype wire

@@ hdl/psps_root_pipe.sv @@
`default_nettype none
// Pipelined root search: one result bit per stage, MSB first.
// Finds largest v with v*v*d <= t. Each stage keeps rem = t - v*v*d and
// vd = v*d, so a trial bit b costs only shifts and adds:
//   (v + 2^b)^2 * d = v*v*d + (vd << (b+1)) + (d << 2b)
// Carries a tag alongside.
module psps_root_pipe #(
  parameter int TAG_W = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire logic                 in_vld,
  input  wire logic [39:0]          in_t,
  input  wire logic [15:0]          in_d,
  input  wire logic [TAG_W-1:0]     in_tag,
  output logic                      out_vld,
  output logic [psps_pkg::ROOT_W-1:0] out_v,
  output logic [TAG_W-1:0]          out_tag
);
  localparam int N  = psps_pkg::ROOT_W;
  localparam int TW = 40;  // remainder
  localparam int PW = 37;  // v*d
  localparam int CW = 60;  // trial term

  logic             vld_q [N];
  logic [TW-1:0]    rem_q [N];
  logic [PW-1:0]    vd_q  [N];
  logic [15:0]      d_q   [N];
  logic [N-1:0]     v_q   [N];
  logic [TAG_W-1:0] tg_q  [N];

  logic             vld_n [N];
  logic [TW-1:0]    rem_n [N];
  logic [PW-1:0]    vd_n  [N];
  logic [15:0]      d_n   [N];
  logic [N-1:0]     v_n   [N];
  logic [TAG_W-1:0] tg_n  [N];

  logic             vld_s;
  logic [TW-1:0]    rem_s;
  logic [PW-1:0]    vd_s;
  logic [15:0]      d_s;
  logic [N-1:0]     v_s;
  logic [TAG_W-1:0] tg_s;
  logic [CW-1:0]    need;

  always_comb begin
    for (int s = 0; s < N; s++) begin
      if (s == 0) begin
        vld_s = in_vld;
        rem_s = in_t;
        vd_s  = '0;
        d_s   = in_d;
        v_s   = '0;
        tg_s  = in_tag;
      end else begin
        vld_s = vld_q[s-1];
        rem_s = rem_q[s-1];
        vd_s  = vd_q[s-1];
        d_s   = d_q[s-1];
        v_s   = v_q[s-1];
        tg_s  = tg_q[s-1];
      end
      need = (CW'(vd_s) << (N - s)) + (CW'(d_s) << (2 * (N - 1 - s)));
      vld_n[s] = vld_s;
      d_n[s]   = d_s;
      tg_n[s]  = tg_s;
      if (need <= CW'(rem_s)) begin
        rem_n[s] = rem_s - TW'(need);
        vd_n[s]  = vd_s + (PW'(d_s) << (N - 1 - s));
        v_n[s]   = v_s | (N'(1) << (N - 1 - s));
      end else begin
        rem_n[s] = rem_s;
        vd_n[s]  = vd_s;
        v_n[s]   = v_s;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < N; s++) begin
      if (rst) begin
        vld_q[s] <= 1'b0;
      end else if (en) begin
        vld_q[s] <= vld_n[s];
      end
      if (en) begin
        rem_q[s] <= rem_n[s];
        vd_q[s]  <= vd_n[s];
        d_q[s]   <= d_n[s];
        v_q[s]   <= v_n[s];
        tg_q[s]  <= tg_n[s];
      end
    end
  end

  assign out_vld = vld_q[N-1];
  assign out_v   = v_q[N-1];
  assign out_tag = tg_q[N-1];
endmodule
`default_nettype wire

@@ hdl/psps_smooth_mem.sv @@
`default_nettype none
// Per-partial smoother state: one synchronous RAM, read-modify-write with
// forwarding from the write stage. Valid bits stand in for the zero reset.
module psps_smooth_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                en,
  input  wire logic                rd_vld,
  input  wire logic [AW-1:0]       rd_addr,
  input  wire logic                upd_vld,   // aligned with read data
  input  wire logic                upd_hold,
  input  wire logic signed [15:0]  upd_target,
  input  wire logic [16:0]         ratio,
  output logic signed [15:0]       upd_value
);
  logic signed [15:0] mem [DEPTH];
  logic [DEPTH-1:0]   valid;
  logic signed [15:0] rdata;
  logic               rvalid;
  logic [AW-1:0]      addr_q;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic signed [15:0] wr_data;
  logic signed [15:0] cur;
  logic signed [17:0] diff;
  logic signed [35:0] prod;

  // a write landing at the read edge is taken from the write stage
  always_ff @(posedge clk) begin
    if (en && rd_vld) begin
      if (wr_en && wr_addr == rd_addr) begin
        rdata  <= wr_data;
        rvalid <= 1'b1;
      end else begin
        rdata  <= mem[rd_addr];
        rvalid <= valid[rd_addr];
      end
      addr_q <= rd_addr;
    end
  end

  // forward the value being written this cycle to the same entry
  always_comb begin
    cur = rvalid ? rdata : 16'sd0;
    if (wr_en && wr_addr == addr_q) cur = wr_data;
    diff = 18'(upd_target) - 18'(cur);
    prod = 36'(signed'({1'b0, ratio})) * 36'(diff) + 36'sd32768;
    upd_value = psps_pkg::sat16(36'(cur) + (prod >>> 16));
  end

  // write stage holds while the pipe stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_en <= 1'b0;
      valid <= '0;
    end else if (en) begin
      wr_en <= upd_vld && !upd_hold;
      if (upd_vld && !upd_hold) valid[addr_q] <= 1'b1;
    end
    if (en) begin
      wr_addr <= addr_q;
      wr_data <= upd_value;
    end
    if (wr_en) mem[wr_addr] <= wr_data;
  end
endmodule
`default_nettype wire

@@ hdl/partial_stereo_pan_smoother.sv @@
// Pipeline: 21 root stages, one pan / memory-read register and one output
// register lie between the accepting edge and out_valid.
// Throughput: one word per cycle; the whole pipe advances when the output
// register is empty or taken, set by the shared stall of the pipeline.
// Reset: rst synchronous, clears config to defaults and marks all smoother
// entries as zero via valid bits; no clearing pass.
`default_nettype none
`include "partial_stereo_pan_smoother_defines.svh"
module partial_stereo_pan_smoother #(
  parameter int NUM_PARTIALS = 64
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire psps_pkg::in_word_t  in_word,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output psps_pkg::out_word_t      out_word,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [16:0]         cfg_data
);
  // a 6-bit index reaches at most 64 entries
  localparam int DEPTH = (NUM_PARTIALS < 64) ? NUM_PARTIALS : 64;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TAG_W = 6 + 16 + 1 + 1;

  psps_pkg::cfg_t cfg;
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stereo_mode     <= psps_pkg::MODE_MONO;
      cfg.swap_sides      <= 1'b0;
      cfg.lowest_partial  <= 15'd256;
      cfg.smoothing_ratio <= 17'd65536;
    end else if (cfg_we) begin
      unique case (cfg_index)
        psps_pkg::REG_MODE:  cfg.stereo_mode     <= cfg_data[1:0];
        psps_pkg::REG_SWAP:  cfg.swap_sides      <= cfg_data[0];
        psps_pkg::REG_LOW:   cfg.lowest_partial  <= cfg_data[14:0];
        psps_pkg::REG_RATIO: cfg.smoothing_ratio <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline advances when output register can take a word
  logic en;
  assign en = !out_valid || out_ready;
  assign in_ready = en;

  // soft-pan distance and squared magnitude feed the root pipe
  logic [15:0] lsub, pos, span;
  logic [15:0] mag;
  logic [31:0] tsq;
  always_comb begin
    lsub = (cfg.lowest_partial > 15'd512) ? 16'(cfg.lowest_partial - 15'd512) : 16'd0;
    pos  = {2'b0, in_word.partial_index, 8'd0} + 16'd256;
    span = (pos > lsub) ? 16'(pos - lsub) : 16'd0;
    mag  = in_word.raw_amplitude[15] ? 16'(-in_word.raw_amplitude) : in_word.raw_amplitude;
    tsq  = 32'(mag) * 32'(mag);
  end
  // search compares v*v*d against a*a*256
  logic [39:0] tsc;
  assign tsc = {tsq, 8'd0};
  logic        rp_vld;
  logic [psps_pkg::ROOT_W-1:0] rp_v;
  logic [TAG_W-1:0] rp_tag;
  logic [15:0] d_eff;
  // zero distance gives no attenuated side; any nonzero d keeps the search sane
  assign d_eff = (span == 16'd0) ? 16'd1 : span;

  logic        pz_vld;
  psps_root_pipe #(.TAG_W(TAG_W)) u_root (
    .clk, .rst, .en,
    .in_vld(in_valid && in_ready),
    .in_t(tsc), .in_d(d_eff),
    .in_tag({in_word.partial_index, in_word.raw_amplitude, in_word.goes_left,
             span != 16'd0}),
    .out_vld(rp_vld), .out_v(rp_v), .out_tag(rp_tag)
  );
  assign pz_vld = rp_vld;

  // pan stage
  logic [5:0]        p_idx;
  logic signed [15:0] p_amp;
  logic              p_left;
  logic              p_span_ok;
  logic signed [15:0] other, tl, tr;
  always_comb begin
    p_idx = rp_tag[23:18];
    p_amp = rp_tag[17:2];
    p_left = rp_tag[1] ^ cfg.swap_sides;
    p_span_ok = rp_tag[0];
    other = 16'sd0;
    if (cfg.stereo_mode == psps_pkg::MODE_SOFT && p_span_ok) begin
      other = p_amp[15] ? psps_pkg::sat16(-36'(rp_v)) : psps_pkg::sat16(36'(rp_v));
    end
    if (cfg.stereo_mode == psps_pkg::MODE_MONO) begin
      tl = p_amp; tr = 16'sd0;
    end else if (p_idx == 6'd0) begin
      tl = p_amp; tr = p_amp;
    end else if (p_left) begin
      tl = p_amp; tr = other;
    end else begin
      tl = other; tr = p_amp;
    end
  end

  logic in_range;
  assign in_range = 32'(p_idx) < NUM_PARTIALS;

  logic              m_vld, m_mono, m_ok;
  logic signed [15:0] m_tl, m_tr;
  always_ff @(posedge clk) begin
    if (rst) m_vld <= 1'b0;
    else if (en) m_vld <= pz_vld;
    if (en) begin
      m_tl <= tl; m_tr <= tr; m_ok <= in_range;
      m_mono <= cfg.stereo_mode == psps_pkg::MODE_MONO;
    end
  end

  logic signed [15:0] lv, rv;
  psps_smooth_mem #(.DEPTH(DEPTH), .AW(AW)) u_left (
    .clk, .rst, .en, .rd_vld(pz_vld && in_range), .rd_addr(AW'(p_idx)),
    .upd_vld(m_vld && m_ok), .upd_hold(1'b0), .upd_target(m_tl),
    .ratio(cfg.smoothing_ratio), .upd_value(lv)
  );
  psps_smooth_mem #(.DEPTH(DEPTH), .AW(AW)) u_right (
    .clk, .rst, .en, .rd_vld(pz_vld && in_range), .rd_addr(AW'(p_idx)),
    .upd_vld(m_vld && m_ok), .upd_hold(m_mono), .upd_target(m_tr),
    .ratio(cfg.smoothing_ratio), .upd_value(rv)
  );

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= m_vld;
    if (en) begin
      out_word.left_amplitude  <= m_ok ? lv : 16'sd0;
      out_word.right_amplitude <= (m_ok && !m_mono) ? rv : 16'sd0;
    end
  end

  `PSPS_ASSERT_NEXT(a_hold_out, clk, rst, out_valid && !out_ready, out_valid)
  `PSPS_ASSERT_IMP(a_ready_en, clk, !rst && in_ready, (!out_valid || out_ready))
endmodule
`default_nettype wire
